>>> hdl/mrw_pkg.sv
// Shared widths and defaults for the Miller-Rabin witness round unit.
package mrw_pkg;

    // Width of the candidate and witness ports
    localparam int MRW_IN_W     = 63;
    // Default operand width used inside the datapath
    localparam int MRW_NUM_BITS = 63;

endpackage

>>> hdl/miller_rabin_witness_round_unit.sv
// One Miller-Rabin witness round: accepts (n, a) and reports a probable-prime verdict.
// Each word is handled alone. The candidate's low NUM_BITS bits form n; a
// candidate below three goes straight to S_DONE, which then returns bad_candidate.
// Otherwise the unit strips trailing zeros of n-1 (one bit per cycle), reduces
// the witness modulo n, raises it to d by square-and-multiply and then squares
// up to r times. All products go through one bit-serial modular multiplier.
// The result word sits in an output register, so a waiting result does not
// block acceptance of the next word.
module miller_rabin_witness_round_unit import mrw_pkg::*; #(
    parameter int NUM_BITS = MRW_NUM_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MRW_IN_W-1:0] i_candidate,
    input  logic [MRW_IN_W-1:0] i_witness,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_probably_prime,
    output logic                o_bad_candidate
);

    localparam int CW = $clog2(NUM_BITS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPLIT = 4'd1;
    localparam logic [3:0] S_RED   = 4'd2;
    localparam logic [3:0] S_POW   = 4'd3;
    localparam logic [3:0] S_PMUL  = 4'd4;
    localparam logic [3:0] S_PSQR  = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_LOOP  = 4'd7;
    localparam logic [3:0] S_LSQ   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]          r_state, n_state;
    logic [NUM_BITS-1:0] r_n, n_n;
    logic [NUM_BITS-1:0] r_a, n_a;
    logic [NUM_BITS-1:0] r_d, n_d;
    logic [NUM_BITS-1:0] r_e, n_e;
    logic [NUM_BITS-1:0] r_base, n_base;
    logic [NUM_BITS-1:0] r_acc, n_acc;
    logic [CW-1:0]       r_r, n_r;
    logic [CW-1:0]       r_i, n_i;
    logic                r_pass, n_pass;
    logic                r_bad, n_bad;
    logic                r_ovalid, n_ovalid;
    logic                r_opp, n_opp;
    logic                r_obad, n_obad;

    logic                w_start;
    logic [NUM_BITS-1:0] w_mx;
    logic [NUM_BITS-1:0] w_my;
    logic                w_done;
    logic [NUM_BITS-1:0] w_res;
    logic [NUM_BITS-1:0] w_nm1;
    logic [NUM_BITS-1:0] w_cand;
    logic [NUM_BITS-1:0] w_one;

    assign w_cand = i_candidate[NUM_BITS-1:0];
    assign w_nm1  = r_n - 1'b1;
    assign w_one  = NUM_BITS'(1);

    mrw_modmul #(.NUM_BITS(NUM_BITS)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_x      (w_mx),
        .i_y      (w_my),
        .i_m      (r_n),
        .o_done   (w_done),
        .o_result (w_res)
    );

    // Sequence one round
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_a      = r_a;
        n_d      = r_d;
        n_e      = r_e;
        n_base   = r_base;
        n_acc    = r_acc;
        n_r      = r_r;
        n_i      = r_i;
        n_pass   = r_pass;
        n_bad    = r_bad;
        n_ovalid = r_ovalid & i_stall;
        n_opp    = r_opp;
        n_obad   = r_obad;
        w_start  = 1'b0;
        w_mx     = r_base;
        w_my     = r_base;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_n = w_cand;
                    n_a = i_witness[NUM_BITS-1:0];
                    n_d = w_cand - 1'b1;
                    n_r = '0;
                    n_pass = 1'b0;
                    if (w_cand < NUM_BITS'(3)) begin
                        n_bad   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_bad   = 1'b0;
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                if (!r_d[0]) begin
                    n_d = r_d >> 1;
                    n_r = r_r + 1'b1;
                end else begin
                    // witness mod n as witness * 1
                    w_start = 1'b1;
                    w_mx    = r_a;
                    w_my    = w_one;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (w_done) begin
                    n_base  = w_res;
                    n_acc   = w_one;
                    n_e     = r_d;
                    n_state = S_POW;
                end
            end
            S_POW: begin
                if (r_e == '0) begin
                    n_state = S_CHK;
                end else if (r_e[0]) begin
                    w_start = 1'b1;
                    w_mx    = r_acc;
                    w_my    = r_base;
                    n_state = S_PMUL;
                end else begin
                    w_start = 1'b1;
                    n_state = S_PSQR;
                end
            end
            S_PMUL: begin
                if (w_done) begin
                    n_acc   = w_res;
                    w_start = 1'b1;
                    n_state = S_PSQR;
                end
            end
            S_PSQR: begin
                if (w_done) begin
                    n_base  = w_res;
                    n_e     = r_e >> 1;
                    n_state = S_POW;
                end
            end
            S_CHK: begin
                n_i = '0;
                if (r_acc == w_one) begin
                    n_pass  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (r_i == r_r) begin
                    n_state = S_DONE;
                end else if (r_acc == w_nm1) begin
                    n_pass  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + 1'b1;
                    w_start = 1'b1;
                    w_mx    = r_acc;
                    w_my    = r_acc;
                    n_state = S_LSQ;
                end
            end
            S_LSQ: begin
                if (w_done) begin
                    n_acc   = w_res;
                    n_state = S_LOOP;
                end
            end
            S_DONE: begin
                // hand the word over once the output register is free
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_opp    = r_pass & ~r_bad;
                    n_obad   = r_bad;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_a    <= n_a;
        r_d    <= n_d;
        r_e    <= n_e;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_r    <= n_r;
        r_i    <= n_i;
        r_pass <= n_pass;
        r_bad  <= n_bad;
        r_opp  <= n_opp;
        r_obad <= n_obad;
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_probably_prime = r_opp;
    assign o_bad_candidate  = r_obad;

    a_bad_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_bad_candidate && o_probably_prime))
        else $error("bad candidate reported as probably prime");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_RED || r_state == S_PMUL ||
                    r_state == S_PSQR || r_state == S_LSQ))
        else $error("product finished outside a wait state");

    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP || r_state == S_LSQ) |-> (r_i <= r_r))
        else $error("squaring count passed r");

endmodule

>>> hdl/mrw_cell.sv
// One bit cell of the multiplier operand chain: load, or take the neighbor's bit.
module mrw_cell (
    input  logic i_clk,
    input  logic i_load,
    input  logic i_shift,
    input  logic i_load_bit,
    input  logic i_next_bit,
    output logic o_bit
);

    logic r_bit;
    logic n_bit;

    // Pick load value, neighbor bit, or hold
    always_comb begin
        n_bit = r_bit;
        if (i_load) begin
            n_bit = i_load_bit;
        end else if (i_shift) begin
            n_bit = i_next_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_bit = r_bit;

endmodule

>>> hdl/mrw_modmul.sv
// Bit-serial modular multiplier: operand x walks down a chain of bit cells.
module mrw_modmul import mrw_pkg::*; #(
    parameter int NUM_BITS = MRW_NUM_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_x,
    input  logic [NUM_BITS-1:0] i_y,
    input  logic [NUM_BITS-1:0] i_m,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_result
);

    localparam int CW = $clog2(NUM_BITS);
    localparam logic [CW-1:0] LAST = CW'(NUM_BITS - 1);

    logic [NUM_BITS-1:0] w_bit;
    logic [NUM_BITS:0]   w_sum;
    logic [NUM_BITS:0]   w_dbl;
    logic [NUM_BITS:0]   w_m;
    logic [NUM_BITS:0]   w_acc_full;
    logic [NUM_BITS:0]   w_y_full;

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [NUM_BITS-1:0] r_acc;
    logic [NUM_BITS-1:0] r_y;
    logic                n_busy;
    logic                n_done;
    logic [CW-1:0]       n_cnt;
    logic [NUM_BITS-1:0] n_acc;
    logic [NUM_BITS-1:0] n_y;

    // Chain of operand cells, lowest bit feeds the adder
    for (genvar k = 0; k < NUM_BITS; k++) begin : g_cell
        logic w_next;
        if (k == NUM_BITS - 1) begin : g_top
            assign w_next = 1'b0;
        end else begin : g_mid
            assign w_next = w_bit[k+1];
        end
        mrw_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (i_start),
            .i_shift    (r_busy),
            .i_load_bit (i_x[k]),
            .i_next_bit (w_next),
            .o_bit      (w_bit[k])
        );
    end

    // Add-and-reduce step and doubling of y
    always_comb begin
        w_m        = {1'b0, i_m};
        w_sum      = {1'b0, r_acc} + (w_bit[0] ? {1'b0, r_y} : '0);
        w_acc_full = (w_sum >= w_m) ? (w_sum - w_m) : w_sum;
        w_dbl      = {r_y, 1'b0};
        w_y_full   = (w_dbl >= w_m) ? (w_dbl - w_m) : w_dbl;
    end

    // Advance one operand bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_y    = r_y;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_y    = i_y;
        end else if (r_busy) begin
            n_acc = w_acc_full[NUM_BITS-1:0];
            n_y   = w_y_full[NUM_BITS-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_y   <= n_y;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier started while busy");

endmodule
